@@ src/top_k_score_selector_defines.svh @@
// ----------------------------------------------------------------------------
// Top-K score selector assertion macros
// Shared concurrent assertion shorthands for the selector RTL.
// ----------------------------------------------------------------------------
`ifndef TOP_K_SCORE_SELECTOR_DEFINES_SVH
`define TOP_K_SCORE_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TKS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TKS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/tks_pkg.sv @@
// ----------------------------------------------------------------------------
// Top-K score selector package
// Field widths, the reset constant and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package tks_pkg;

  localparam int ID_W    = 32;
  localparam int SCORE_W = 17;
  localparam int CNT_W   = 5;

  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  typedef struct packed {
    logic offer_wr;
    logic scan_go;
    logic scan_max;
    logic fin_start;
    logic load;
    logic clear;
    logic cfg_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic take;
    logic scan_done;
    logic live_zero;
    logic fin_last;
    logic out_free;
  } dp_sts_t;

endpackage

@@ src/tks_in_if.sv @@
// ----------------------------------------------------------------------------
// Top-K score selector input channel
// Valid/ready channel carrying one offer or finish item.
// ----------------------------------------------------------------------------
interface tks_in_if;
  import tks_pkg::*;

  logic               valid;
  logic               ready;
  logic               action;
  logic [ID_W-1:0]    item_id;
  logic [SCORE_W-1:0] score;

  modport source (output valid, output action, output item_id, output score, input ready);
  modport sink   (input valid, input action, input item_id, input score, output ready);
endinterface

@@ src/tks_out_if.sv @@
// ----------------------------------------------------------------------------
// Top-K score selector result channel
// Valid/ready channel carrying one emitted best entry.
// ----------------------------------------------------------------------------
interface tks_out_if;
  import tks_pkg::*;

  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    best_id;
  logic [SCORE_W-1:0] best_score;
  logic               valid_res;
  logic               last;

  modport source (output valid, output best_id, output best_score, output valid_res,
                  output last, input ready);
  modport sink   (input valid, input best_id, input best_score, input valid_res,
                  input last, output ready);
endinterface

@@ src/tks_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Top-K score selector configuration channel
// Valid/ready write channel for the count_in_use register.
// ----------------------------------------------------------------------------
interface tks_cfg_if;
  import tks_pkg::*;

  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] count_in_use;

  modport source (output valid, output count_in_use, input ready);
  modport sink   (input valid, input count_in_use, output ready);
endinterface

@@ src/tks_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tks_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

@@ src/tks_ctrl.sv @@
// ----------------------------------------------------------------------------
// Top-K score selector controller
// Sequences configuration writes, offers, minimum scans, finish passes and result loads.
// ----------------------------------------------------------------------------
module tks_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_action,
  output logic             in_ready,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output tks_pkg::dp_cmd_t cmd,
  input  tks_pkg::dp_sts_t sts
);
  import tks_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MIN_SCAN,
    S_FIN_SCAN,
    S_FIN_LOAD
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end else if (in_valid) begin
          if (!in_action) begin
            // keep the candidate only if it beats the current minimum
            if (sts.take) begin
              cmd.offer_wr = 1'b1;
              cmd.scan_go  = 1'b1;
              state_nxt    = S_MIN_SCAN;
            end
          end else begin
            cmd.fin_start = 1'b1;
            if (sts.live_zero) begin
              state_nxt = S_FIN_LOAD;
            end else begin
              cmd.scan_go  = 1'b1;
              cmd.scan_max = 1'b1;
              state_nxt    = S_FIN_SCAN;
            end
          end
        end
      end
      S_MIN_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = S_FIN_LOAD;
        end
      end
      S_FIN_LOAD: begin
        if (sts.out_free) begin
          cmd.load = 1'b1;
          if (sts.fin_last) begin
            cmd.clear = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            cmd.scan_go  = 1'b1;
            cmd.scan_max = 1'b1;
            state_nxt    = S_FIN_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/tks_datapath.sv @@
// ----------------------------------------------------------------------------
// Top-K score selector datapath
// Slot RAM, valid/emitted flags, scan unit, minimum and best trackers,
// and the result register.
// ----------------------------------------------------------------------------
module tks_datapath #(
  parameter int SLOTS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tks_pkg::dp_cmd_t              cmd,
  output tks_pkg::dp_sts_t              sts,
  input  logic [tks_pkg::ID_W-1:0]      in_item_id,
  input  logic [tks_pkg::SCORE_W-1:0]   in_score,
  input  logic [tks_pkg::CNT_W-1:0]     cfg_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tks_pkg::ID_W-1:0]      out_best_id,
  output logic [tks_pkg::SCORE_W-1:0]   out_best_score,
  output logic                          out_valid_res,
  output logic                          out_last
);
  import tks_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = ID_W + SCORE_W;

  logic [CNT_W-1:0]   count_r;
  logic [CW-1:0]      n_w;
  logic [SLOTS-1:0]   vld_r;
  logic [SLOTS-1:0]   done_r;
  logic [SCORE_W-1:0] min_score_r;
  logic [IW-1:0]      min_slot_r;
  logic [CW-1:0]      live_cnt_r;
  logic [CW-1:0]      rem_r;

  logic               issuing_r;
  logic               mode_max_r;
  logic [IW-1:0]      scan_addr_r;
  logic               issue_last;
  logic               pend_r;
  logic               pend_last_r;
  logic [IW-1:0]      pend_idx_r;
  logic               rd_vld_r;
  logic [EW-1:0]      rdata;

  logic [ID_W-1:0]    e_id;
  logic [SCORE_W-1:0] e_score;
  logic               e_nz;
  logic               cand;

  logic               found_r;
  logic [ID_W-1:0]    best_id_r;
  logic [SCORE_W-1:0] best_score_r;
  logic [IW-1:0]      best_slot_r;

  logic               out_valid_r;

  assign n_w = (int'(count_r) > SLOTS) ? CW'(SLOTS) : CW'(count_r);

  tks_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.offer_wr),
    .waddr (min_slot_r),
    .wdata ({in_item_id, in_score}),
    .raddr (scan_addr_r),
    .rdata (rdata)
  );

  // a slot never written since the last clear reads as empty
  assign e_id    = rd_vld_r ? rdata[EW-1:SCORE_W] : '0;
  assign e_score = rd_vld_r ? rdata[SCORE_W-1:0]  : '0;
  assign e_nz    = (e_id != '0);
  assign cand    = e_nz && !done_r[pend_idx_r];

  assign issue_last = (CW'(scan_addr_r) == (n_w - CW'(1)));

  assign sts.take      = (n_w != '0) && (in_score > min_score_r);
  assign sts.scan_done = pend_r && pend_last_r;
  assign sts.live_zero = (live_cnt_r == '0);
  assign sts.fin_last  = (rem_r <= CW'(1));
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= COUNT_RESET;
      vld_r       <= '0;
      done_r      <= '0;
      min_score_r <= '0;
      min_slot_r  <= '0;
      live_cnt_r  <= '0;
      rem_r       <= '0;
      issuing_r   <= 1'b0;
      mode_max_r  <= 1'b0;
      scan_addr_r <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // scan issue: one slot address per cycle
      if (cmd.scan_go) begin
        scan_addr_r <= '0;
        issuing_r   <= 1'b1;
        mode_max_r  <= cmd.scan_max;
        found_r     <= 1'b0;
      end else if (issuing_r) begin
        if (issue_last) begin
          issuing_r <= 1'b0;
        end else begin
          scan_addr_r <= scan_addr_r + IW'(1);
        end
      end
      pend_r <= issuing_r;

      // minimum scan: lowest index with strictly smallest score, recount entries
      if (pend_r && !mode_max_r) begin
        if ((pend_idx_r == '0) || (e_score < min_score_r)) begin
          min_score_r <= e_score;
          min_slot_r  <= pend_idx_r;
        end
        if (pend_idx_r == '0) begin
          live_cnt_r <= CW'(e_nz);
        end else begin
          live_cnt_r <= live_cnt_r + CW'(e_nz);
        end
      end

      // finish pass: first remaining entry with strictly largest score
      if (pend_r && mode_max_r && cand && (!found_r || (e_score > best_score_r))) begin
        found_r <= 1'b1;
      end

      if (cmd.offer_wr) begin
        vld_r[min_slot_r] <= 1'b1;
      end

      if (cmd.fin_start) begin
        rem_r <= live_cnt_r;
      end

      if (cmd.load) begin
        out_valid_r <= 1'b1;
        if (rem_r != '0) begin
          done_r[best_slot_r] <= 1'b1;
          rem_r               <= rem_r - CW'(1);
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.cfg_wr) begin
        count_r <= cfg_count;
      end

      if (cmd.clear || cmd.cfg_wr) begin
        vld_r       <= '0;
        done_r      <= '0;
        min_score_r <= '0;
        min_slot_r  <= '0;
        live_cnt_r  <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_idx_r  <= scan_addr_r;
    pend_last_r <= issue_last;
    rd_vld_r    <= vld_r[scan_addr_r];
    if (pend_r && mode_max_r && cand && (!found_r || (e_score > best_score_r))) begin
      best_id_r    <= e_id;
      best_score_r <= e_score;
      best_slot_r  <= pend_idx_r;
    end
    if (cmd.load) begin
      out_best_id    <= (rem_r != '0) ? best_id_r    : '0;
      out_best_score <= (rem_r != '0) ? best_score_r : '0;
      out_valid_res  <= (rem_r != '0);
      out_last       <= (rem_r <= CW'(1));
    end
  end

endmodule

@@ src/top_k_score_selector.sv @@
// ----------------------------------------------------------------------------
// Top-K score selector
// Keeps the best (id, score) pairs of a stream and emits them sorted.
// ----------------------------------------------------------------------------
// Keeps up to n = min(count_in_use, SLOTS) best (item_id, score) pairs. An
// offer (action 0) whose score is strictly above the current minimum
// overwrites the minimum slot; the block then scans the n slots, one per
// cycle out of the slot RAM, to find the new minimum (lowest index wins a
// tie) and to recount the non-empty slots. A kept offer therefore occupies
// the block until that scan is over; a dropped offer is accepted without a
// scan. A finish (action 1) runs one scan pass over the n slots per emitted
// entry, each pass picking the remaining non-empty slot with the largest
// score (lowest index on a tie). Entries with id 0 are never emitted; when
// nothing is left a single result with valid_res = 0 and last = 1 is
// returned. The result register decouples the output: the next pass runs
// while a result waits, and offers are taken while the final result of a
// finish is still pending. After a finish, or a write of count_in_use, the
// store is empty again at once (per slot valid flags, no clearing pass).
// Configuration is taken only when idle.
// ----------------------------------------------------------------------------
`include "top_k_score_selector_defines.svh"

module top_k_score_selector #(
  parameter int SLOTS = 16
) (
  input logic       clk,
  input logic       rst_n,
  tks_in_if.sink    in_ch,
  tks_out_if.source out_ch,
  tks_cfg_if.sink   cfg_ch
);
  import tks_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequence offers, scans and result loads
  tks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // hold slots, track minimum and best, drive the result register
  tks_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_item_id     (in_ch.item_id),
    .in_score       (in_ch.score),
    .cfg_count      (cfg_ch.count_in_use),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_best_id    (out_ch.best_id),
    .out_best_score (out_ch.best_score),
    .out_valid_res  (out_ch.valid_res),
    .out_last       (out_ch.last)
  );

  // an item and a register write never complete in the same cycle
  `TKS_ASSERT_SAME(a_in_cfg_excl, clk, rst_n, in_ch.valid && in_ch.ready, !(cfg_ch.valid && cfg_ch.ready), "item and config write accepted together")

  // never overwrite a result that is still waiting
  `TKS_ASSERT_SAME(a_load_free, clk, rst_n, cmd.load, sts.out_free, "result register loaded while occupied")

  // a clear empties the entry count
  `TKS_ASSERT_NEXT(a_clear_empty, clk, rst_n, cmd.clear, sts.live_zero, "store not empty after clear")

  // a scan never starts while one is still running
  `TKS_ASSERT_SAME(a_scan_idle, clk, rst_n, cmd.scan_go, !sts.scan_done, "scan started over a running scan")

endmodule
